@@ hw/rtl/ssdf_pkg.sv @@
// shared constants and types for the suspension spring-damper force block
`timescale 1ns / 1ps
package ssdf_pkg;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_REST_LENGTH = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_EXT = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_COMP = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_STIFFNESS = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DAMPING = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ANTI_SQUAT = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_ANTI_DIVE = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_CAMBER_RATE = 3'd7;

	localparam logic [30:0] MIN_STEP = 31'd66;
	localparam logic [16:0] NINE_TENTHS = 17'd58982;
	localparam logic signed [33:0] TENTH = 34'sd6554;
	localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

	// datapath operations issued by the controller
	localparam logic [3:0] OP_SETUP = 4'd0;
	localparam logic [3:0] OP_RATE_DIV = 4'd1;
	localparam logic [3:0] OP_RATIO_DIV = 4'd2;
	localparam logic [3:0] OP_THR = 4'd3;
	localparam logic [3:0] OP_SPRING = 4'd4;
	localparam logic [3:0] OP_DAMP = 4'd5;
	localparam logic [3:0] OP_BUMP = 4'd6;
	localparam logic [3:0] OP_BOOST1 = 4'd7;
	localparam logic [3:0] OP_BOOST2 = 4'd8;
	localparam logic [3:0] OP_CAMBER = 4'd9;
	localparam logic [3:0] OP_FINISH = 4'd10;

	typedef struct packed {
		logic       go;
		logic [3:0] op;
	} ssdf_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic grounded;
	} ssdf_status_t;

	typedef struct packed {
		logic [30:0] rest_len;
		logic [30:0] ext_lim;
		logic [30:0] comp_lim;
		logic [30:0] stiff_k;
		logic [30:0] damp_c;
		logic [30:0] squat_gain;
		logic [30:0] dive_gain;
		logic signed [31:0] camber_k;
	} ssdf_cfg_t;

	// signed Q16.16 product of exact operands, truncated toward zero, saturated
	function automatic logic signed [33:0] qsat(input logic signed [65:0] p);
		logic        neg;
		logic [65:0] mag;
		logic [65:0] sh;
		logic signed [65:0] r;
		neg = p[65];
		mag = neg ? 66'(-p) : 66'(p);
		sh = mag >> 16;
		r = neg ? 66'(-$signed(sh)) : $signed(sh);
		if (r > S32_MAX) r = S32_MAX;
		if (r < S32_MIN) r = S32_MIN;
		return 34'(r);
	endfunction
endpackage

@@ hw/rtl/ssdf_div.sv @@
// radix-2 signed restoring divider, quotient truncated toward zero
`timescale 1ns / 1ps
module ssdf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [48:0] dividend,
	input  logic [31:0]        divisor,
	output logic               busy,
	output logic signed [48:0] quotient
);
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [47:0] num_q;
	logic [47:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [32:0] trial;

	assign busy = (cnt_q != 6'd0);
	assign trial = {rem_q, num_q[47]};
	assign quotient = neg_q ? 49'(-$signed({1'b0, quo_q})) : $signed({1'b0, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd48;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[48];
			num_q <= dividend[48] ? 48'(-dividend) : dividend[47:0];
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[46:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= 32'(trial - {1'b0, den_q});
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end
endmodule

@@ hw/rtl/ssdf_datapath.sv @@
// datapath: config registers, previous length, one shared multiplier and divider
`timescale 1ns / 1ps
module ssdf_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ssdf_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [ssdf_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         load,
	input  logic [95:0]                  in_word,
	input  ssdf_pkg::ssdf_cmd_t          cmd,
	output ssdf_pkg::ssdf_status_t       status,
	output logic [119:0]                 result
);
	import ssdf_pkg::*;

	ssdf_cfg_t cfg_q;
	logic [31:0] prev_q;
	logic        hit_q;
	logic [30:0] dist_q;
	logic [30:0] ts_q;
	logic signed [33:0] accel_q;

	logic        grounded_q;
	logic [31:0] length_q;
	logic signed [33:0] rate_q, comp_q, thr_q, total_q, force_q, tmp_q, camber_q;
	logic [16:0] ratio_q;

	logic               div_start;
	logic signed [48:0] div_num;
	logic [31:0]        div_den;
	logic               div_busy;
	logic signed [48:0] div_quo;

	logic signed [33:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic signed [33:0] qp;
	logic [31:0] probe;
	logic signed [65:0] s_total;
	logic signed [33:0] comp_cl;
	logic signed [33:0] damp_total;
	logic signed [37:0] bump_x10, bump_sat;

	ssdf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .busy(div_busy), .quotient(div_quo)
	);

	assign probe = {1'b0, cfg_q.rest_len} + {1'b0, cfg_q.ext_lim};
	assign status.div_busy = div_busy;
	assign status.grounded = grounded_q;

	always_comb begin
		div_start = cmd.go && (cmd.op == OP_RATE_DIV || cmd.op == OP_RATIO_DIV);
		if (cmd.op == OP_RATE_DIV) begin
			div_num = 49'($signed({1'b0, length_q}) - $signed({1'b0, prev_q})) <<< 16;
			div_den = (ts_q < MIN_STEP) ? {1'b0, MIN_STEP} : {1'b0, ts_q};
		end else begin
			div_num = 49'(comp_q) <<< 16;
			div_den = {1'b0, cfg_q.comp_lim};
		end
	end

	always_comb begin
		comp_cl = comp_q;
		if (comp_cl < -$signed({3'b0, cfg_q.ext_lim}))
			comp_cl = -$signed({3'b0, cfg_q.ext_lim});
		if (comp_cl > $signed({3'b0, cfg_q.comp_lim}))
			comp_cl = $signed({3'b0, cfg_q.comp_lim});
		case (cmd.op)
			OP_SPRING: begin mul_a = $signed({3'b0, cfg_q.stiff_k}); mul_b = comp_q; end
			OP_DAMP: begin mul_a = $signed({3'b0, cfg_q.damp_c}); mul_b = rate_q; end
			OP_BUMP: begin mul_a = comp_q - thr_q; mul_b = $signed({3'b0, cfg_q.stiff_k}); end
			OP_BOOST1: begin mul_a = accel_q[33] ? -accel_q : accel_q; mul_b = force_q; end
			OP_BOOST2: begin
				mul_a = tmp_q;
				mul_b = accel_q[33] ? $signed({3'b0, cfg_q.dive_gain})
					: $signed({3'b0, cfg_q.squat_gain});
			end
			OP_CAMBER: begin mul_a = $signed({17'b0, ratio_q}); mul_b = 34'(cfg_q.camber_k); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		prod = mul_a * mul_b;
		qp = qsat(prod);
		damp_total = total_q - qp;
		// bump stop term, ten times the excess spring force, saturated
		bump_x10 = 38'(qp) * 38'sd10;
		bump_sat = (bump_x10 > 38'sd2147483647) ? 38'sd2147483647 : bump_x10;
		s_total = 66'(total_q) + 66'(bump_sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_len <= 31'd32768;
			cfg_q.ext_lim <= 31'd13107;
			cfg_q.comp_lim <= 31'd19661;
			cfg_q.stiff_k <= 31'd1966080000;
			cfg_q.damp_c <= 31'd196608000;
			cfg_q.squat_gain <= '0;
			cfg_q.dive_gain <= '0;
			cfg_q.camber_k <= '0;
			prev_q <= 32'd32768;
			grounded_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_REST_LENGTH: begin
						cfg_q.rest_len <= cfg_data[30:0];
						prev_q <= {1'b0, cfg_data[30:0]};
					end
					REG_MAX_EXT: cfg_q.ext_lim <= cfg_data[30:0];
					REG_MAX_COMP: cfg_q.comp_lim <= cfg_data[30:0];
					REG_STIFFNESS: cfg_q.stiff_k <= cfg_data[30:0];
					REG_DAMPING: cfg_q.damp_c <= cfg_data[30:0];
					REG_ANTI_SQUAT: cfg_q.squat_gain <= cfg_data[30:0];
					REG_ANTI_DIVE: cfg_q.dive_gain <= cfg_data[30:0];
					REG_CAMBER_RATE: cfg_q.camber_k <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (cmd.go && cmd.op == OP_SETUP)
				grounded_q <= hit_q && ({1'b0, dist_q} <= probe);
			if (cmd.go && cmd.op == OP_FINISH)
				prev_q <= length_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hit_q <= in_word[0];
			dist_q <= in_word[31:1];
			ts_q <= in_word[62:32];
			accel_q <= 34'($signed(in_word[94:63]));
		end
		if (cmd.go) begin
			case (cmd.op)
				OP_SETUP: begin
					length_q <= (hit_q && ({1'b0, dist_q} <= probe)) ? {1'b0, dist_q} : probe;
					comp_q <= $signed({3'b0, cfg_q.rest_len})
						- $signed({3'b0, dist_q});
					ratio_q <= '0;
					camber_q <= '0;
					force_q <= '0;
				end
				OP_RATE_DIV: ;
				OP_RATIO_DIV: begin
					// capture rate, then compute ratio later
					rate_q <= (div_quo > 49'sd2147483647) ? 34'sd2147483647
						: (div_quo < -49'sd2147483648) ? -34'sd2147483648 : 34'(div_quo);
				end
				OP_THR: begin
					if (!grounded_q)
						ratio_q <= '0;
					else if (cfg_q.comp_lim == '0)
						ratio_q <= (comp_q > 0) ? 17'd65536 : 17'd0;
					else if (div_quo < 0)
						ratio_q <= '0;
					else if (div_quo > 49'sd65536)
						ratio_q <= 17'd65536;
					else
						ratio_q <= div_quo[16:0];
					thr_q <= 34'(({17'b0, cfg_q.comp_lim} * {31'b0, NINE_TENTHS}) >> 16);
					comp_q <= comp_cl;
				end
				OP_SPRING: total_q <= qp;
				OP_DAMP: begin
					total_q <= damp_total;
					if (comp_q < thr_q) begin
						if (damp_total < 0)
							force_q <= 34'sd0;
						else if (damp_total > 34'sd2147483647)
							force_q <= 34'sd2147483647;
						else
							force_q <= damp_total;
					end
				end
				OP_BUMP: begin
					if (comp_q >= thr_q) begin
						force_q <= (s_total < 0) ? 34'sd0
							: (s_total > S32_MAX) ? S32_MAX[33:0] : 34'(s_total);
					end
				end
				OP_BOOST1: tmp_q <= qp;
				OP_BOOST2: begin
					if (force_q > 0 && (accel_q >= TENTH || accel_q <= -TENTH)) begin
						force_q <= (66'(force_q) + 66'(qp) > S32_MAX) ? S32_MAX[33:0]
							: force_q + qp;
					end
				end
				OP_CAMBER: camber_q <= qp;
				default: ;
			endcase
		end
	end

	// rate is captured from the divider on the RATIO_DIV issue cycle
	assign result = {camber_q[31:0], rate_q[31:0], ratio_q, force_q[30:0], grounded_q,
		7'b0};
endmodule

@@ hw/rtl/ssdf_ctrl.sv @@
// controller: sequences one item through the shared datapath units
`timescale 1ns / 1ps
module ssdf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_fire,
	input  logic                   out_free,
	input  ssdf_pkg::ssdf_status_t status,
	output ssdf_pkg::ssdf_cmd_t    cmd,
	output logic                   busy,
	output logic                   done
);
	import ssdf_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SETUP = 4'd1;
	localparam logic [3:0] S_RDIV = 4'd2;
	localparam logic [3:0] S_RWAIT = 4'd3;
	localparam logic [3:0] S_CDIV = 4'd4;
	localparam logic [3:0] S_CWAIT = 4'd5;
	localparam logic [3:0] S_MATH = 4'd6;
	localparam logic [3:0] S_OUT = 4'd7;

	logic [3:0] state_q;
	logic [3:0] op_q;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT) && out_free;

	always_comb begin
		cmd.go = 1'b0;
		cmd.op = OP_SETUP;
		case (state_q)
			S_SETUP: begin cmd.go = 1'b1; cmd.op = OP_SETUP; end
			S_RDIV: begin cmd.go = 1'b1; cmd.op = OP_RATE_DIV; end
			S_CDIV: begin cmd.go = 1'b1; cmd.op = OP_RATIO_DIV; end
			S_MATH: begin cmd.go = 1'b1; cmd.op = op_q; end
			S_OUT: begin cmd.go = done; cmd.op = OP_FINISH; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_THR;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_SETUP;
				S_SETUP: state_q <= S_RDIV;
				S_RDIV: state_q <= S_RWAIT;
				S_RWAIT: if (!status.div_busy) state_q <= S_CDIV;
				S_CDIV: state_q <= S_CWAIT;
				S_CWAIT: if (!status.div_busy) begin
					state_q <= S_MATH;
					op_q <= OP_THR;
				end
				S_MATH: begin
					if (!status.grounded || op_q == OP_CAMBER) state_q <= S_OUT;
					else op_q <= op_q + 4'd1;
				end
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_div_in_math: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MATH |-> !status.div_busy) else $error("divider busy in math");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == S_IDLE) else $error("done did not return idle");
	a_start_setup: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && in_fire |=> state_q == S_SETUP) else $error("no setup");
`endif
endmodule

@@ hw/rtl/suspension_spring_damper_force.sv @@
// top level: stream ports, output word register, controller and datapath
// results take fewer steps without valid contact, as the math steps after OP_THR are skipped
// a new word is accepted only when the controller is idle; each word runs two 48-step divisions
// the next word is taken while a finished result still waits on m_axis
// reset: arst_n clears control and loads register defaults; previous length = rest length
`timescale 1ns / 1ps
module suspension_spring_damper_force (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// contact_found, hit_distance, time_step, accel_forward
	input  logic [95:0]                   s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// grounded, upward force, compression ratio, compression_rate, camber_delta
	output logic [119:0]                  m_axis_tdata,
	input  logic                          cfg_we,
	input  logic [ssdf_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ssdf_pkg::CfgDataW-1:0] cfg_data
);
	import ssdf_pkg::*;

	ssdf_cmd_t    cmd;
	ssdf_status_t status;
	logic         busy, done, in_fire, out_free;
	logic [119:0] res;
	logic [119:0] out_q;
	logic         ov_q;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !ov_q || m_axis_tready;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = out_q;

	ssdf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.status(status), .cmd(cmd), .busy(busy), .done(done)
	);

	ssdf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .load(in_fire), .in_word(s_axis_tdata), .cmd(cmd),
		.status(status), .result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (done) begin
			ov_q <= 1'b1;
		end else if (m_axis_tready) begin
			ov_q <= 1'b0;
		end
	end

	// pack fields low bit first
	always_ff @(posedge clk) begin
		if (done) out_q <= {7'b0, res[119:7]};
	end
endmodule
